// File: sv/sgs_pkg.sv
package sgs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 7;
    localparam int GAIN_W   = 2 * VOL_W;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    localparam int MAG_W    = PROD_W - 1;
    localparam int QUOT_W   = 17;
    localparam int CLIP_W   = QUOT_W + 1;
    localparam int IDX_W    = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [MAG_W-1:0] GAIN_DIV    = MAG_W'(10000);
    localparam int               RECIP_SHIFT = 43;
    localparam logic [MAG_W-1:0] RECIP_M     = MAG_W'((64'd1 << RECIP_SHIFT) / 64'd10000);
    localparam int               RECIP_W     = 2 * MAG_W;

    localparam logic signed [CLIP_W-1:0] S8_MIN  = -CLIP_W'(128);
    localparam logic signed [CLIP_W-1:0] S8_MAX  = CLIP_W'(127);
    localparam logic signed [CLIP_W-1:0] S16_MIN = -CLIP_W'(32768);
    localparam logic signed [CLIP_W-1:0] S16_MAX = CLIP_W'(32767);

    localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(100);

    typedef enum logic {
        FMT_U8  = 1'b0,
        FMT_S16 = 1'b1
    } sample_fmt_t;

    typedef enum logic [IDX_W-1:0] {
        REG_MASTER = 3'd0,
        REG_LEFT   = 3'd1,
        REG_RIGHT  = 3'd2,
        REG_FORMAT = 3'd3,
        REG_STEREO = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [VOL_W-1:0] master;
        logic [VOL_W-1:0] left;
        logic [VOL_W-1:0] right;
        sample_fmt_t      fmt;
        logic             stereo;
    } sgs_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic [GAIN_W-1:0]   gain;
        sample_fmt_t         fmt;
    } sgs_entry_t;

    typedef struct packed {
        logic       en;
        sgs_entry_t data;
    } sgs_wr_t;

endpackage

// File: sv/pcm_stereo_gain_saturate.sv
// PCM gain stage with saturation, one sample per transfer.
// Input channel: sample_in and first_of_buffer are taken on a rising edge with push high
// and full low. Result channel: sample_out holds the oldest result while empty is low,
// and pop with empty low takes it.
// Configuration channel: cfg_index selects master, left, right, format or stereo mode,
// cfg_data carries the value, and a transfer completes on cfg_valid with cfg_ready high.
// cfg_ready is always high; write registers only while no samples are in flight.
// An accepted sample goes through the queue and the five-stage multiply, reciprocal divide
// and clip pipeline before empty falls; one sample per cycle while the receiver pops.
// Reset sets all volumes to 100, the format to signed 16-bit, stereo mode on, the
// next sample to left, and empties the queue and pipeline.
// When the receiver stalls, the pipeline stages fill, then the four-entry queue
// between front and back fills, and full rises after nine samples are held.
module pcm_stereo_gain_saturate
    import sgs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [SAMPLE_W-1:0] sample_in,
    input  logic                first_of_buffer,
    output logic                empty,
    input  logic                pop,
    output logic [SAMPLE_W-1:0] sample_out,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [VOL_W-1:0]    cfg_data
);

    sgs_cfg_t   cfg_reg;
    sgs_cfg_t   cfg_next;
    sgs_wr_t    q_wr;
    logic       q_rd_en;
    logic       q_rd_valid;
    sgs_entry_t q_rd_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MASTER: cfg_next.master = cfg_data;
                REG_LEFT:   cfg_next.left   = cfg_data;
                REG_RIGHT:  cfg_next.right  = cfg_data;
                REG_FORMAT: cfg_next.fmt    = sample_fmt_t'(cfg_data[0]);
                REG_STEREO: cfg_next.stereo = cfg_data[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.master <= VOL_RESET;
            cfg_reg.left   <= VOL_RESET;
            cfg_reg.right  <= VOL_RESET;
            cfg_reg.fmt    <= FMT_S16;
            cfg_reg.stereo <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sgs_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .sample_in       (sample_in),
        .first_of_buffer (first_of_buffer),
        .cfg             (cfg_reg),
        .wr              (q_wr)
    );

    sgs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .rd_en    (q_rd_en),
        .rd_valid (q_rd_valid),
        .rd_data  (q_rd_data),
        .full     (full)
    );

    sgs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_valid   (q_rd_valid),
        .rd_data    (q_rd_data),
        .rd_en      (q_rd_en),
        .pop        (pop),
        .empty      (empty),
        .sample_out (sample_out)
    );

`ifndef SYNTHESIS
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !q_wr.en)
        else $error("queue written while full");

    a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd_en |-> q_rd_valid)
        else $error("queue read while empty");

    a_u8_high_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && cfg_reg.fmt == FMT_U8) |-> (sample_out[15:8] == 8'h00))
        else $error("8-bit result has nonzero high byte");

    a_push_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> q_wr.en)
        else $error("accepted sample not written to queue");
`endif

endmodule

// File: sv/sgs_front.sv
module sgs_front
    import sgs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  logic [SAMPLE_W-1:0] sample_in,
    input  logic                first_of_buffer,
    input  sgs_cfg_t            cfg,
    output sgs_wr_t             wr
);

    logic parity_reg;
    logic parity_next;
    logic parity_cur;
    logic accept;
    logic use_right;
    logic [VOL_W-1:0] chan_vol;
    logic [SAMPLE_W-1:0] val;

    assign accept     = push && !full;
    assign parity_cur = first_of_buffer ? 1'b0 : parity_reg;
    assign use_right  = cfg.stereo && parity_cur;
    assign chan_vol   = use_right ? cfg.right : cfg.left;

    // Offset binary becomes two's complement by flipping the top bit.
    always_comb
    begin
        if (cfg.fmt == FMT_U8)
        begin
            val = {{8{~sample_in[7]}}, ~sample_in[7], sample_in[6:0]};
        end
        else
        begin
            val = sample_in;
        end
    end

    always_comb
    begin
        wr.en        = accept;
        wr.data.val  = val;
        wr.data.gain = GAIN_W'(cfg.master) * GAIN_W'(chan_vol);
        wr.data.fmt  = cfg.fmt;
        parity_next  = accept ? ~parity_cur : parity_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= 1'b0;
        end
        else
        begin
            parity_reg <= parity_next;
        end
    end

endmodule

// File: sv/sgs_queue.sv
module sgs_queue
    import sgs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sgs_wr_t    wr,
    input  logic       rd_en,
    output logic       rd_valid,
    output sgs_entry_t rd_data,
    output logic       full
);

    sgs_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr.en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr.en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr.en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr_ptr_reg] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/sgs_back.sv
module sgs_back
    import sgs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_valid,
    input  sgs_entry_t          rd_data,
    output logic                rd_en,
    input  logic                pop,
    output logic                empty,
    output logic [SAMPLE_W-1:0] sample_out
);

    localparam int NSTAGE = 5;

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] rdy;

    logic signed [PROD_W-1:0] prod_reg;
    sample_fmt_t              fmt1_reg;
    logic [MAG_W-1:0]         mag2_reg;
    logic                     neg2_reg;
    sample_fmt_t              fmt2_reg;
    logic [QUOT_W-1:0]        est3_reg;
    logic [MAG_W-1:0]         mag3_reg;
    logic                     neg3_reg;
    sample_fmt_t              fmt3_reg;
    logic [QUOT_W-1:0]        quot4_reg;
    logic                     neg4_reg;
    sample_fmt_t              fmt4_reg;
    logic [SAMPLE_W-1:0]      out_reg;

    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] abs_c;
    logic [RECIP_W-1:0]       recip_c;
    logic [MAG_W-1:0]         back_mul_c;
    logic [MAG_W-1:0]         rem_c;
    logic [QUOT_W-1:0]        quot_c;
    logic signed [CLIP_W-1:0] signed_c;
    logic signed [CLIP_W-1:0] clip_c;
    logic [SAMPLE_W-1:0]      out_c;

    always_comb
    begin
        rdy[NSTAGE-1] = !vld_reg[NSTAGE-1] || pop;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = rd_valid;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    assign rd_en      = rd_valid && rdy[0];
    assign empty      = !vld_reg[NSTAGE-1];
    assign sample_out = out_reg;

    // Division by the gain scale uses a reciprocal estimate that is at most one low.
    always_comb
    begin
        prod_c     = $signed(rd_data.val) * $signed({1'b0, rd_data.gain});
        abs_c      = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
        recip_c    = RECIP_W'(mag2_reg) * RECIP_W'(RECIP_M);
        back_mul_c = MAG_W'(MAG_W'(est3_reg) * GAIN_DIV);
        rem_c      = mag3_reg - back_mul_c;
        quot_c     = (rem_c >= GAIN_DIV) ? est3_reg + 1'b1 : est3_reg;
        signed_c   = neg4_reg ? -$signed({1'b0, quot4_reg}) : $signed({1'b0, quot4_reg});
        if (fmt4_reg == FMT_U8)
        begin
            if (signed_c < S8_MIN)
            begin
                clip_c = S8_MIN;
            end
            else if (signed_c > S8_MAX)
            begin
                clip_c = S8_MAX;
            end
            else
            begin
                clip_c = signed_c;
            end
            out_c = {8'b0, ~clip_c[7], clip_c[6:0]};
        end
        else
        begin
            if (signed_c < S16_MIN)
            begin
                clip_c = S16_MIN;
            end
            else if (signed_c > S16_MAX)
            begin
                clip_c = S16_MAX;
            end
            else
            begin
                clip_c = signed_c;
            end
            out_c = clip_c[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            prod_reg <= prod_c;
            fmt1_reg <= rd_data.fmt;
        end
        if (rdy[1])
        begin
            mag2_reg <= abs_c[MAG_W-1:0];
            neg2_reg <= prod_reg[PROD_W-1];
            fmt2_reg <= fmt1_reg;
        end
        if (rdy[2])
        begin
            est3_reg <= recip_c[RECIP_SHIFT +: QUOT_W];
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            fmt3_reg <= fmt2_reg;
        end
        if (rdy[3])
        begin
            quot4_reg <= quot_c;
            neg4_reg  <= neg3_reg;
            fmt4_reg  <= fmt3_reg;
        end
        if (rdy[4])
        begin
            out_reg <= out_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    import sgs_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 40;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int U8_BIAS         = 128;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                first;
    } pcm_item_t;

    typedef enum int {
        RX_STEADY,
        RX_BUSY,
        RX_SPARSE,
        RX_HOLD
    } rx_pattern_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [SAMPLE_W-1:0] sample_in = '0;
    logic                first_of_buffer = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [SAMPLE_W-1:0] sample_out;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [VOL_W-1:0]    cfg_data = '0;

    pcm_item_t           samples_to_send[$];
    logic [SAMPLE_W-1:0] awaited_samples[$];

    logic [VOL_W-1:0]    gain_master = VOL_RESET;
    logic [VOL_W-1:0]    gain_left = VOL_RESET;
    logic [VOL_W-1:0]    gain_right = VOL_RESET;
    sample_fmt_t         fmt_now = FMT_S16;
    logic                stereo_now = 1'b1;
    logic                next_is_right = 1'b0;

    int                  errors = 0;
    int                  cycles = 0;
    int                  burst_left = 0;
    int                  gap_left = 0;
    rx_pattern_t         rx_mode = RX_STEADY;
    int                  rx_left = 0;
    pcm_item_t           item_next;
    logic [SAMPLE_W-1:0] want;

    pcm_stereo_gain_saturate dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .sample_in       (sample_in),
        .first_of_buffer (first_of_buffer),
        .empty           (empty),
        .pop             (pop),
        .sample_out      (sample_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [SAMPLE_W-1:0] scaled_sample(logic [SAMPLE_W-1:0] raw,
                                                          logic first);
        logic                parity;
        longint              gain;
        longint              v;
        longint              r;
        logic [SAMPLE_W-1:0] result;
        parity = first ? 1'b0 : next_is_right;
        gain = longint'(gain_master) *
               longint'((stereo_now && parity) ? gain_right : gain_left);
        if (fmt_now == FMT_U8)
        begin
            v = longint'(raw[7:0]) - U8_BIAS;
            r = (v * gain) / longint'(GAIN_DIV);
            if (r < longint'(S8_MIN))
                r = longint'(S8_MIN);
            if (r > longint'(S8_MAX))
                r = longint'(S8_MAX);
            result = {8'h00, 8'(r + U8_BIAS)};
        end
        else
        begin
            v = longint'($signed(raw));
            r = (v * gain) / longint'(GAIN_DIV);
            if (r < longint'(S16_MIN))
                r = longint'(S16_MIN);
            if (r > longint'(S16_MAX))
                r = longint'(S16_MAX);
            result = SAMPLE_W'(r);
        end
        next_is_right = ~parity;
        return result;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 9))
            0: s = SAMPLE_W'(16'h7FFF - $urandom_range(0, 8));
            1: s = SAMPLE_W'(16'h8000 + $urandom_range(0, 8));
            2: s = SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
            3: s = {8'($urandom), 8'h00 | 8'($urandom_range(0, 1) ? 8'hFF : 8'h00)};
            4: s = {8'($urandom), 8'(U8_BIAS + int'($urandom_range(0, 6)) - 3)};
            default: s = SAMPLE_W'($urandom);
        endcase
        return s;
    endfunction

    function automatic logic [VOL_W-1:0] pick_volume();
        logic [VOL_W-1:0] vol;
        case ($urandom_range(0, 5))
            0: vol = '0;
            1: vol = VOL_RESET;
            2: vol = '1;
            default: vol = VOL_W'($urandom_range(0, 127));
        endcase
        return vol;
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [VOL_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MASTER: gain_master = val;
            REG_LEFT:   gain_left = val;
            REG_RIGHT:  gain_right = val;
            REG_FORMAT: fmt_now = sample_fmt_t'(val[0]);
            REG_STEREO: stereo_now = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [VOL_W-1:0] master, logic [VOL_W-1:0] left,
                             logic [VOL_W-1:0] right, sample_fmt_t fmt, logic stereo);
        write_reg(REG_MASTER, master);
        write_reg(REG_LEFT, left);
        write_reg(REG_RIGHT, right);
        write_reg(REG_FORMAT, {6'($urandom), fmt});
        write_reg(REG_STEREO, {6'($urandom), stereo});
    endtask

    task automatic queue_sample(logic [SAMPLE_W-1:0] s, logic first);
        pcm_item_t it;
        it.sample = s;
        it.first  = first;
        samples_to_send.push_back(it);
    endtask

    // The check runs on the falling edge, after every update of the rising edge has settled.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || push || awaited_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (push && !full)
                awaited_samples.push_back(scaled_sample(sample_in, first_of_buffer));
            if (!push || !full)
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (samples_to_send.size() > 0)
                begin
                    item_next = samples_to_send.pop_front();
                    sample_in       <= item_next.sample;
                    first_of_buffer <= item_next.first;
                    push            <= 1'b1;
                    burst_left--;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transfer and stalls on its own pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            rx_left = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (awaited_samples.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t unexpected sample_out: expected none, actual %h",
                                 $time, sample_out);
                end
                else
                begin
                    want = awaited_samples.pop_front();
                    if (sample_out !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t sample_out mismatch: expected %h, actual %h",
                                     $time, want, sample_out);
                    end
                end
            end
            if (rx_left == 0)
            begin
                rx_mode = rx_pattern_t'($urandom_range(0, 3));
                rx_left = $urandom_range(4, 40);
            end
            rx_left--;
            case (rx_mode)
                RX_STEADY: pop <= 1'b1;
                RX_BUSY:   pop <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: pop <= ($urandom_range(0, 4) == 0);
                default:   pop <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int made;
        int buf_len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        queue_sample(16'h7FFF, 1'b1);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'h7FFF, 1'b1);
        wait_drained();

        // Gain of 127 * 127 / 10000 on the left, muted right, 8-bit with high bits set.
        write_all('1, '1, '0, FMT_U8, 1'b1);
        queue_sample(16'hFF00, 1'b1);
        queue_sample(16'h00FF, 1'b0);
        queue_sample(16'h5A7F, 1'b0);
        queue_sample(16'h0081, 1'b1);
        queue_sample(16'hFF01, 1'b0);
        queue_sample(16'h00FE, 1'b0);
        queue_sample(16'hA580, 1'b0);
        wait_drained();

        // Mono leaves the right volume unused while the parity keeps toggling.
        write_all(VOL_RESET, VOL_W'(50), '1, FMT_S16, 1'b0);
        queue_sample(16'h8000, 1'b1);
        queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0003, 1'b0);
        queue_sample(16'h1234, 1'b1);
        queue_sample(16'hC000, 1'b0);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                write_all('0, '0, '0, FMT_U8, 1'b0);
            else if (p == 1)
                write_all('1, '1, '1, FMT_S16, 1'b1);
            else
                write_all(pick_volume(), pick_volume(), pick_volume(),
                          sample_fmt_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (p < 2 || $urandom_range(0, 1) == 0)
                for (int i = int'(REG_STEREO) + 1; i < 2 ** IDX_W; i++)
                    write_reg(IDX_W'(i), VOL_W'($urandom));
            made = 0;
            while (made < ITEMS_PER_PHASE)
            begin
                buf_len = $urandom_range(1, 40);
                for (int k = 0; k < buf_len && made < ITEMS_PER_PHASE; k++)
                begin
                    queue_sample(pick_sample(),
                                 (k == 0) ? ($urandom_range(0, 7) != 0)
                                          : ($urandom_range(0, 15) == 0));
                    made++;
                end
            end
            wait_drained();
        end

        if (errors == 0 && awaited_samples.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
